// File: sv/lbel_pkg.sv
// ----------------------------------------------------------------------------
// lbel_pkg
// Shared widths, register indexes and divider status type for the leaky
// bucket event limiter.
// ----------------------------------------------------------------------------
package lbel_pkg;

  localparam int TIME_BITS_DEF  = 32;
  localparam int COUNT_BITS_DEF = 16;

  localparam int EVT_W      = 32;
  localparam int LIMIT_W    = 16;
  localparam int WINDOW_W   = 32;
  localparam int FILL_W     = 16;
  localparam int CFG_IDX_W  = 8;
  localparam int CFG_DATA_W = 32;

  localparam logic [CFG_IDX_W-1:0] REG_EVENT_LIMIT  = CFG_IDX_W'(0);
  localparam logic [CFG_IDX_W-1:0] REG_WINDOW_TICKS = CFG_IDX_W'(1);

  typedef struct packed {
    logic busy;
    logic done;
  } div_stat_t;

endpackage

// File: sv/lbel_div.sv
// ----------------------------------------------------------------------------
// lbel_div
// Restoring radix-2 divider, one quotient bit per cycle. Quotient and
// remainder hold after done until the next start.
// ----------------------------------------------------------------------------
module lbel_div import lbel_pkg::*; #(
  parameter int DW = WINDOW_W,
  parameter int VW = WINDOW_W
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          start,
  input  logic [DW-1:0] dividend,
  input  logic [VW-1:0] divisor,
  output div_stat_t     stat,
  output logic [DW-1:0] quotient,
  output logic [VW-1:0] remainder
);

  localparam int CNT_W = $clog2(DW + 1);

  logic [DW-1:0]    dvd_r, dvd_nxt;
  logic [VW-1:0]    rem_r, rem_nxt;
  logic [VW-1:0]    dsr_r, dsr_nxt;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;
  logic             done_r, done_nxt;
  logic [VW:0]      trial;
  logic [VW:0]      diff;
  logic             ge;

  assign trial = {rem_r, dvd_r[DW-1]};
  assign diff  = trial - {1'b0, dsr_r};
  assign ge    = trial >= {1'b0, dsr_r};

  always_comb begin
    dvd_nxt  = dvd_r;
    rem_nxt  = rem_r;
    dsr_nxt  = dsr_r;
    cnt_nxt  = cnt_r;
    done_nxt = 1'b0;
    if (start) begin
      dvd_nxt = dividend;
      rem_nxt = '0;
      dsr_nxt = divisor;
      cnt_nxt = CNT_W'(DW);
    end else if (cnt_r != '0) begin
      dvd_nxt  = {dvd_r[DW-2:0], ge};
      rem_nxt  = ge ? diff[VW-1:0] : trial[VW-1:0];
      cnt_nxt  = cnt_r - CNT_W'(1);
      done_nxt = (cnt_r == CNT_W'(1));
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r  <= '0;
      done_r <= 1'b0;
    end else begin
      cnt_r  <= cnt_nxt;
      done_r <= done_nxt;
    end
  end

  always_ff @(posedge clk) begin
    dvd_r <= dvd_nxt;
    rem_r <= rem_nxt;
    dsr_r <= dsr_nxt;
  end

  assign stat.busy = (cnt_r != '0);
  assign stat.done = done_r;
  assign quotient  = dvd_r;
  assign remainder = rem_r;

endmodule

// File: sv/leaky_bucket_event_limiter.sv
// ----------------------------------------------------------------------------
// leaky_bucket_event_limiter
// With limiting on, an accepted event passes through ST_DRAIN (serial divide of
// elapsed time by the drain period, DIV_W = max(TIME_BITS, 32) bits), ST_APPLY,
// ST_ADD and ST_EMIT before the registered result; when disabled, only ST_EMIT.
// A new event is accepted only after the last result is emitted (back in ST_IDLE).
// A write that leaves a nonzero limit stalls input until the drain period is divided.
// Reset: synchronous; count and drain time 0, limit 0, window 1.
// ----------------------------------------------------------------------------
module leaky_bucket_event_limiter import lbel_pkg::*; #(
  parameter int TIME_BITS  = TIME_BITS_DEF,
  parameter int COUNT_BITS = COUNT_BITS_DEF
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  cfg_valid,
  output logic                  cfg_ready,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data,
  input  logic                  in_valid,
  output logic                  in_stall,
  input  logic [EVT_W-1:0]      in_event_time,
  output logic                  out_valid,
  input  logic                  out_stall,
  output logic                  out_limit_reached,
  output logic [FILL_W-1:0]     out_fill_level
);

  localparam int DIV_W = (TIME_BITS > WINDOW_W) ? TIME_BITS : WINDOW_W;
  localparam int CMP_W = (COUNT_BITS + 1 > LIMIT_W) ? COUNT_BITS + 1 : LIMIT_W;

  typedef enum logic [5:0] {
    ST_IDLE   = 6'b000001,
    ST_PERIOD = 6'b000010,
    ST_DRAIN  = 6'b000100,
    ST_APPLY  = 6'b001000,
    ST_ADD    = 6'b010000,
    ST_EMIT   = 6'b100000
  } state_t;

  state_t                state_r, state_nxt;
  logic [LIMIT_W-1:0]    limit_r, limit_nxt;
  logic [WINDOW_W-1:0]   window_r, window_nxt;
  logic [WINDOW_W-1:0]   period_r, period_nxt;
  logic [COUNT_BITS-1:0] cnt_r, cnt_nxt;
  logic [TIME_BITS-1:0]  last_r, last_nxt;
  logic [TIME_BITS-1:0]  now_r, now_nxt;
  logic                  flag_r, flag_nxt;
  logic                  out_valid_r, out_valid_nxt;
  logic                  out_flag_r, out_flag_nxt;
  logic [FILL_W-1:0]     out_fill_r, out_fill_nxt;

  logic                  cfg_fire, in_fire, out_free;
  logic                  cfg_hit_limit, cfg_hit_window;
  logic [LIMIT_W-1:0]    new_limit;
  logic [WINDOW_W-1:0]   new_window;
  logic [TIME_BITS-1:0]  now_in, elapsed;
  logic                  div_start;
  logic [DIV_W-1:0]      div_dividend;
  logic [WINDOW_W-1:0]   div_divisor;
  div_stat_t             div_stat;
  logic [DIV_W-1:0]      div_quo;
  logic [WINDOW_W-1:0]   div_rem;
  logic [COUNT_BITS-1:0] drn_cnt;
  logic [TIME_BITS-1:0]  drn_last;
  logic [COUNT_BITS:0]   inc;
  logic                  over;

  assign cfg_ready = (state_r == ST_IDLE);
  assign in_stall  = (state_r != ST_IDLE) || cfg_valid;
  assign cfg_fire  = cfg_valid && cfg_ready;
  assign in_fire   = in_valid && !in_stall;
  assign out_free  = !out_valid_r || !out_stall;

  assign cfg_hit_limit  = (cfg_index == REG_EVENT_LIMIT);
  assign cfg_hit_window = (cfg_index == REG_WINDOW_TICKS);
  assign new_limit  = cfg_hit_limit ? cfg_data[LIMIT_W-1:0] : limit_r;
  assign new_window = cfg_hit_window ? cfg_data[WINDOW_W-1:0] : window_r;

  assign now_in  = TIME_BITS'(in_event_time);
  assign elapsed = now_in - last_r;

  assign div_start = (cfg_fire && (cfg_hit_limit || cfg_hit_window) && new_limit != '0) ||
                     (in_fire && limit_r != '0);
  assign div_dividend = cfg_fire ? DIV_W'(new_window) : DIV_W'(elapsed);
  assign div_divisor  = cfg_fire ? WINDOW_W'(new_limit) : period_r;

  lbel_div #(
    .DW (DIV_W),
    .VW (WINDOW_W)
  ) u_div (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (div_start),
    .dividend  (div_dividend),
    .divisor   (div_divisor),
    .stat      (div_stat),
    .quotient  (div_quo),
    .remainder (div_rem)
  );

  // drain whole periods; keep the partial period on the drain time
  always_comb begin
    drn_cnt  = cnt_r;
    drn_last = last_r;
    if (cnt_r != '0 && div_quo != '0) begin
      if (div_quo < DIV_W'(cnt_r)) begin
        drn_cnt  = cnt_r - COUNT_BITS'(div_quo);
        drn_last = now_r - TIME_BITS'(div_rem);
      end else begin
        drn_cnt = '0;
      end
    end
  end

  assign inc  = {1'b0, cnt_r} + (COUNT_BITS + 1)'(1);
  assign over = inc[COUNT_BITS] || (CMP_W'(inc) > CMP_W'(limit_r));

  always_comb begin
    state_nxt     = state_r;
    limit_nxt     = limit_r;
    window_nxt    = window_r;
    period_nxt    = period_r;
    cnt_nxt       = cnt_r;
    last_nxt      = last_r;
    now_nxt       = now_r;
    flag_nxt      = flag_r;
    out_valid_nxt = out_valid_r && out_stall;
    out_flag_nxt  = out_flag_r;
    out_fill_nxt  = out_fill_r;
    case (state_r)
      ST_IDLE: begin
        if (cfg_fire) begin
          if (cfg_hit_limit || cfg_hit_window) begin
            limit_nxt  = new_limit;
            window_nxt = new_window;
            cnt_nxt    = '0;
            last_nxt   = '0;
            if (new_limit != '0) begin
              state_nxt = ST_PERIOD;
            end
          end
        end else if (in_fire) begin
          now_nxt = now_in;
          if (limit_r != '0) begin
            state_nxt = ST_DRAIN;
          end else begin
            flag_nxt  = 1'b0;
            state_nxt = ST_EMIT;
          end
        end
      end
      ST_PERIOD: begin
        if (div_stat.done) begin
          period_nxt = (div_quo == '0) ? WINDOW_W'(1) : div_quo[WINDOW_W-1:0];
          state_nxt  = ST_IDLE;
        end
      end
      ST_DRAIN: begin
        if (div_stat.done) begin
          state_nxt = ST_APPLY;
        end
      end
      ST_APPLY: begin
        cnt_nxt   = drn_cnt;
        last_nxt  = (drn_cnt == '0) ? now_r : drn_last;
        state_nxt = ST_ADD;
      end
      ST_ADD: begin
        if (over) begin
          cnt_nxt  = '0;
          last_nxt = now_r;
          flag_nxt = 1'b1;
        end else begin
          cnt_nxt  = inc[COUNT_BITS-1:0];
          flag_nxt = 1'b0;
        end
        state_nxt = ST_EMIT;
      end
      ST_EMIT: begin
        if (out_free) begin
          out_valid_nxt = 1'b1;
          out_flag_nxt  = flag_r;
          out_fill_nxt  = FILL_W'(cnt_r);
          state_nxt     = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      limit_r     <= '0;
      window_r    <= WINDOW_W'(1);
      cnt_r       <= '0;
      last_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      limit_r     <= limit_nxt;
      window_r    <= window_nxt;
      cnt_r       <= cnt_nxt;
      last_r      <= last_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    period_r   <= period_nxt;
    now_r      <= now_nxt;
    flag_r     <= flag_nxt;
    out_flag_r <= out_flag_nxt;
    out_fill_r <= out_fill_nxt;
  end

  assign out_valid         = out_valid_r;
  assign out_limit_reached = out_flag_r;
  assign out_fill_level    = out_fill_r;

  a_onehot_state: assert property (@(posedge clk) disable iff (!rst_n)
    $onehot(state_r))
    else $error("state register not one-hot");

  a_drain_has_div: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_DRAIN || state_r == ST_PERIOD) |-> (div_stat.busy || div_stat.done))
    else $error("waiting on divider that is not running");

  a_count_in_limit: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_IDLE && limit_r != '0) |-> (CMP_W'(cnt_r) <= CMP_W'(limit_r)))
    else $error("bucket count above limit");

  a_overflow_empties: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_limit_reached) |-> (out_fill_level == '0))
    else $error("overflow result with nonempty bucket");

  a_event_starts_div: assert property (@(posedge clk) disable iff (!rst_n)
    (in_fire && limit_r != '0) |=> (state_r == ST_DRAIN && div_stat.busy))
    else $error("enabled event did not start the divider");

endmodule
